/* sv/rcw_pkg.sv */
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants for the reno congestion window
// Holds command codes, transaction structs, reset values and sizes that the
// front end, queue, back end and top level all use.
// ----------------------------------------------------------------------------
package rcw_pkg;

  // default width of the window, threshold and prior window state
  localparam int unsigned WINDOW_BITS_DEF = 32;

  // configuration reset values
  localparam logic [15:0] MTU_RESET            = 16'd1200;
  localparam logic [31:0] INIT_WINDOW_RESET    = 32'd12000;
  localparam logic [31:0] INIT_THRESHOLD_RESET = 32'hFFFF_FFFF;

  // configuration register indexes (byte address 4*i)
  localparam logic [1:0] REG_MTU            = 2'd0;
  localparam logic [1:0] REG_INIT_WINDOW    = 2'd1;
  localparam logic [1:0] REG_INIT_THRESHOLD = 2'd2;

  // op queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  // serial divider: one quotient bit per cycle over a 32-bit dividend
  localparam int unsigned DIV_NUM_BITS = 32;
  localparam int unsigned DIV_CNT_W    = 5;

  // event commands
  typedef enum logic [1:0] {
    CMD_ACK  = 2'd0,
    CMD_LOSS = 2'd1,
    CMD_IDLE = 2'd2,
    CMD_SNAP = 2'd3
  } cmd_e;

  // input transaction
  typedef struct packed {
    cmd_e        command;
    logic [15:0] acked_bytes;
    logic [31:0] now_ms;
    logic        idle_value;
  } rcw_in_t;

  // result transaction
  typedef struct packed {
    logic [31:0] window_bytes;
    logic [31:0] threshold_bytes;
    logic [31:0] prior_window_bytes;
    logic        idle_state;
    logic [31:0] loss_time_ms;
  } rcw_out_t;

  // classified op: arg carries mtu*acked for ack, now_ms for loss,
  // the idle flag in bit 0 for idle update
  typedef struct packed {
    cmd_e        kind;
    logic [15:0] acked;
    logic [31:0] arg;
  } rcw_op_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] mtu;
    logic        win_load;
    logic [31:0] win_value;
    logic        thr_load;
    logic [31:0] thr_value;
  } rcw_cfg_t;

  // back end status toward queue and top level
  typedef struct packed {
    logic pop;
    logic busy;
  } rcw_bk_stat_t;

endpackage

/* sv/reno_congestion_window.sv */
// ----------------------------------------------------------------------------
// reno_congestion_window: reno congestion window tracker
// Applies ack, loss, idle and snapshot events to the congestion window state
// and returns one result transaction per event.
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o     rcw_in_t
// out       output     out_valid_o / out_stall_i   rcw_out_t
// cfg       input      psel/penable/pwrite/pready  pwdata, paddr (apb)
//
// an accepted transaction is registered in the op queue, then taken by the back
// end, which registers the result at once for loss, idle, snapshot, slow-start
// and zero-window acks; a congestion avoidance ack first runs the serial divider
// (start, 32 steps, write-back) before its result is registered.
// reset empties the queue and the result register and loads the window state
// from the default initial values. a stalled output holds the back end, and
// the two-entry op queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module reno_congestion_window #(
  parameter int unsigned WINDOW_BITS = rcw_pkg::WINDOW_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rcw_pkg::rcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rcw_pkg::rcw_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0]           mtu_q;
  logic [31:0]           init_win_q;
  logic [31:0]           init_thr_q;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  rcw_pkg::rcw_cfg_t     cfg;
  logic                  q_full;
  logic                  q_empty;
  logic                  push;
  rcw_pkg::rcw_op_t      push_op;
  rcw_pkg::rcw_op_t      head_op;
  rcw_pkg::rcw_bk_stat_t bk_stat;

  // apb register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q      <= rcw_pkg::MTU_RESET;
      init_win_q <= rcw_pkg::INIT_WINDOW_RESET;
      init_thr_q <= rcw_pkg::INIT_THRESHOLD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rcw_pkg::REG_MTU:            mtu_q      <= pwdata[15:0];
        rcw_pkg::REG_INIT_WINDOW:    init_win_q <= pwdata;
        rcw_pkg::REG_INIT_THRESHOLD: init_thr_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcw_pkg::REG_MTU:            prdata = {16'd0, mtu_q};
      rcw_pkg::REG_INIT_WINDOW:    prdata = init_win_q;
      rcw_pkg::REG_INIT_THRESHOLD: prdata = init_thr_q;
      default:                     prdata = '0;
    endcase
  end

  // a write of an initial value also loads the live register
  assign cfg.mtu       = mtu_q;
  assign cfg.win_load  = cfg_wr && (reg_idx == rcw_pkg::REG_INIT_WINDOW);
  assign cfg.win_value = pwdata;
  assign cfg.thr_load  = cfg_wr && (reg_idx == rcw_pkg::REG_INIT_THRESHOLD);
  assign cfg.thr_value = pwdata;

  rcw_front u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .mtu_i     (mtu_q),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .op_o      (push_op)
  );

  rcw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .pop_i    (bk_stat.pop),
    .full_o   (q_full),
    .empty_o  (q_empty),
    .head_o   (head_op)
  );

  rcw_back #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .op_valid_i (!q_empty),
    .op_i       (head_op),
    .stat_o     (bk_stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // the back end never takes from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !q_empty)
    else $error("op taken from empty queue");

  // an op is taken only when the result register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> (!out_valid_o || !out_stall_i))
    else $error("op taken while result register is blocked");

  // no new op while a division is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.busy |-> !bk_stat.pop)
    else $error("op taken while divider busy");

  // events other than ack register their result in the cycle they are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.pop && (head_op.kind != rcw_pkg::CMD_ACK)) |=> out_valid_o)
    else $error("single-cycle event produced no result");

endmodule

/* sv/rcw_front.sv */
// ----------------------------------------------------------------------------
// rcw_front: input acceptance and event classification
// Takes input transactions while the op queue has room, forms the
// congestion avoidance product mtu*acked and packs each event into an op.
// ----------------------------------------------------------------------------
module rcw_front (
  input  logic             in_valid_i,
  input  rcw_pkg::rcw_in_t in_data_i,
  input  logic [15:0]      mtu_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             push_o,
  output rcw_pkg::rcw_op_t op_o
);

  logic [31:0] product;

  // stall only on a full queue
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // growth numerator for congestion avoidance
  assign product = 32'(mtu_i) * 32'(in_data_i.acked_bytes);

  // pick the argument each command needs
  always_comb begin
    op_o.kind  = in_data_i.command;
    op_o.acked = in_data_i.acked_bytes;
    unique case (in_data_i.command)
      rcw_pkg::CMD_ACK:  op_o.arg = product;
      rcw_pkg::CMD_LOSS: op_o.arg = in_data_i.now_ms;
      rcw_pkg::CMD_IDLE: op_o.arg = {31'd0, in_data_i.idle_value};
      default:           op_o.arg = '0;
    endcase
  end

endmodule

/* sv/rcw_queue.sv */
// ----------------------------------------------------------------------------
// rcw_queue: short op queue between front and back
// A small register queue that decouples event acceptance from execution.
// ----------------------------------------------------------------------------
module rcw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rcw_pkg::rcw_op_t push_op_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output rcw_pkg::rcw_op_t head_o
);

  rcw_pkg::rcw_op_t                mem_q [rcw_pkg::QUEUE_DEPTH];
  logic [rcw_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rcw_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rcw_pkg::QUEUE_AW:0]      count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = (count_q == (rcw_pkg::QUEUE_AW + 1)'(rcw_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

/* sv/rcw_div.sv */
// ----------------------------------------------------------------------------
// rcw_div: serial restoring divider
// Divides a 32-bit numerator by a window-wide divisor, one quotient bit per
// cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module rcw_div #(
  parameter int unsigned WINDOW_BITS = rcw_pkg::WINDOW_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            num_i,
  input  logic [WINDOW_BITS-1:0] den_i,
  output logic                   done_o,
  output logic [31:0]            quot_o
);

  logic [WINDOW_BITS-1:0]        rem_q, rem_d;
  logic [WINDOW_BITS-1:0]        den_q;
  logic [31:0]                   quo_q, quo_d;
  logic [rcw_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [WINDOW_BITS:0]          shifted;
  logic [WINDOW_BITS:0]          diff;
  logic                          ge;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, den_q};
    ge      = (shifted >= {1'b0, den_q});
    rem_d   = ge ? diff[WINDOW_BITS-1:0] : shifted[WINDOW_BITS-1:0];
    quo_d   = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rcw_pkg::DIV_CNT_W'(rcw_pkg::DIV_NUM_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* sv/rcw_back.sv */
// ----------------------------------------------------------------------------
// rcw_back: event execution and result register
// Owns the window state, executes one op at a time, runs the serial divider
// for congestion avoidance and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rcw_back #(
  parameter int unsigned WINDOW_BITS = rcw_pkg::WINDOW_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcw_pkg::rcw_cfg_t     cfg_i,
  input  logic                  op_valid_i,
  input  rcw_pkg::rcw_op_t      op_i,
  output rcw_pkg::rcw_bk_stat_t stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rcw_pkg::rcw_out_t     out_data_o
);

  localparam int unsigned MW    = (WINDOW_BITS > 32) ? WINDOW_BITS : 32;
  localparam int unsigned SUM_W = MW + 1;
  localparam logic [WINDOW_BITS-1:0] WMAX = {WINDOW_BITS{1'b1}};

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                   state_q, state_d;
  logic [WINDOW_BITS-1:0] win_q, win_d;
  logic [WINDOW_BITS-1:0] thr_q, thr_d;
  logic [WINDOW_BITS-1:0] prior_q, prior_d;
  logic                   idle_q, idle_d;
  logic [31:0]            loss_q, loss_d;
  logic                   out_valid_q, out_valid_d;
  rcw_pkg::rcw_out_t      out_q;
  logic                   slot_free;
  logic                   pop;
  logic                   load_out;
  logic                   div_start;
  logic                   div_done;
  logic [31:0]            div_quot;
  logic [WINDOW_BITS-1:0] half;
  logic [WINDOW_BITS-1:0] floor_thr;

  // saturate a 32-bit value to the window range
  function automatic logic [WINDOW_BITS-1:0] clamp32(logic [31:0] v);
    logic [MW-1:0] ext;
    ext = MW'(v);
    if (ext > MW'(WMAX)) begin
      return WMAX;
    end
    return ext[WINDOW_BITS-1:0];
  endfunction

  // window plus growth, stopping at the maximum
  function automatic logic [WINDOW_BITS-1:0] sat_add(logic [WINDOW_BITS-1:0] a,
                                                      logic [31:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum > SUM_W'(WMAX)) begin
      return WMAX;
    end
    return sum[WINDOW_BITS-1:0];
  endfunction

  // low 32 bits of a window-wide value
  function automatic logic [31:0] lo32(logic [WINDOW_BITS-1:0] v);
    logic [MW-1:0] ext;
    ext = MW'(v);
    return ext[31:0];
  endfunction

  rcw_div #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (op_i.arg),
    .den_i  (win_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // take an op only when the result register can hold its result
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop       = (state_q == ST_IDLE) && op_valid_i && slot_free;

  assign half      = win_q >> 1;
  assign floor_thr = WINDOW_BITS'({cfg_i.mtu, 1'b0});

  // next state of the window registers
  always_comb begin
    state_d   = state_q;
    win_d     = win_q;
    thr_d     = thr_q;
    prior_d   = prior_q;
    idle_d    = idle_q;
    loss_d    = loss_q;
    div_start = 1'b0;
    load_out  = 1'b0;

    // initial values load on configuration writes
    if (cfg_i.win_load) begin
      win_d = clamp32(cfg_i.win_value);
    end
    if (cfg_i.thr_load) begin
      thr_d = clamp32(cfg_i.thr_value);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          load_out = 1'b1;
          unique case (op_i.kind)
            rcw_pkg::CMD_ACK: begin
              priority if (win_q < thr_q) begin
                win_d = sat_add(win_q, 32'(op_i.acked));
              end else if (win_q == '0) begin
                win_d = WMAX;
              end else begin
                div_start = 1'b1;
                load_out  = 1'b0;
                state_d   = ST_DIV;
              end
            end
            rcw_pkg::CMD_LOSS: begin
              prior_d = win_q;
              thr_d   = (half > floor_thr) ? half : floor_thr;
              win_d   = thr_d;
              loss_d  = op_i.arg;
            end
            rcw_pkg::CMD_IDLE: begin
              idle_d = op_i.arg[0];
            end
            default: begin
              prior_d = win_q;
            end
          endcase
        end
      end
      default: begin
        if (div_done) begin
          win_d    = sat_add(win_q, div_quot);
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= clamp32(rcw_pkg::INIT_WINDOW_RESET);
      thr_q       <= clamp32(rcw_pkg::INIT_THRESHOLD_RESET);
      prior_q     <= '0;
      idle_q      <= 1'b0;
      loss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      thr_q       <= thr_d;
      prior_q     <= prior_d;
      idle_q      <= idle_d;
      loss_q      <= loss_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.window_bytes       <= lo32(win_d);
      out_q.threshold_bytes    <= lo32(thr_d);
      out_q.prior_window_bytes <= lo32(prior_d);
      out_q.idle_state         <= idle_d;
      out_q.loss_time_ms       <= loss_d;
    end
  end

  assign stat_o.pop  = pop;
  assign stat_o.busy = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
